@@ hdl/pli_pkg.sv @@
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and codes for the positional list: request and status codes,
// the per-cell shift command and the controller state.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int REQ_BITS    = 2;
    localparam int POS_BITS    = 8;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 2;

    localparam logic [REQ_BITS-1:0] REQ_INSERT     = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_REMOVE_POS = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_REMOVE_VAL = 2'd2;
    localparam logic [REQ_BITS-1:0] REQ_DUMP       = 2'd3;

    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_RANGE     = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_DELVAL,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

endpackage

@@ hdl/pli_cell.sv @@
// ----------------------------------------------------------------------------
// pli_cell
// One slot of the list. Holds a word and, on command, loads the new value or
// takes the word of its left or right neighbor or of the head slot.
// ----------------------------------------------------------------------------
module pli_cell #(
    parameter int WORD_BITS = 32,
    parameter int CNT_W     = 5,
    parameter int INDEX     = 0
) (
    input  logic                 clk,
    input  pli_pkg::cell_op_t    op,
    input  logic [CNT_W-1:0]     pos,
    input  logic [CNT_W-1:0]     count,
    input  logic [WORD_BITS-1:0] value,
    input  logic [WORD_BITS-1:0] left_data,
    input  logic [WORD_BITS-1:0] right_data,
    input  logic [WORD_BITS-1:0] head_data,
    input  logic                 found_in,
    output logic                 found_out,
    output logic [WORD_BITS-1:0] data
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic                 match;

    // only slots holding a live entry take part in the search
    assign match     = (MY_IDX < count) && (data_reg == value);
    assign found_out = found_in | match;
    assign data      = data_reg;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            pli_pkg::CELL_INSERT:
            begin
                if (MY_IDX > pos)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == pos)
                begin
                    data_next = value;
                end
            end
            pli_pkg::CELL_DELETE:
            begin
                if (MY_IDX >= pos)
                begin
                    data_next = right_data;
                end
            end
            pli_pkg::CELL_DELVAL:
            begin
                // close the gap at and after the first match
                if (found_out)
                begin
                    data_next = right_data;
                end
            end
            pli_pkg::CELL_ROTATE:
            begin
                // wrap the head word into the last live slot
                if (MY_IDX == pos)
                begin
                    data_next = head_data;
                end
                else
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ hdl/positional_list_insert_remove.sv @@
// Insert and remove requests finish in the cycle they are accepted; the result
// is registered and shows in the next cycle, one request per cycle unless
// stalled. A dump of N entries streams them one per cycle unless stalled,
// rotating the cell chain N times; requests are held off until the last result
// is loaded. Reset clears count and control state; slot contents stay undefined.
// ----------------------------------------------------------------------------
// positional_list_insert_remove
// Ordered word list built as a chain of cells that shift together on insert,
// remove by position, remove by first equal value and dump.
// ----------------------------------------------------------------------------
module positional_list_insert_remove #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [pli_pkg::REQ_BITS-1:0]        req_type,
    input  logic [pli_pkg::POS_BITS-1:0]        position,
    input  logic [pli_pkg::VALUE_BITS-1:0]      value,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic [pli_pkg::VALUE_BITS-1:0]      entry,
    output logic [$clog2(DEPTH+1)-1:0]          count_after,
    output logic [pli_pkg::STATUS_BITS-1:0]     status,
    output logic                                last
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > pli_pkg::POS_BITS) ? CNT_W : pli_pkg::POS_BITS;
    localparam int VB    = pli_pkg::VALUE_BITS;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pli_pkg::state_t   state_reg, state_next;
    pli_pkg::cell_op_t cell_op;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  dump_left_reg, dump_left_next;
    logic [CNT_W-1:0]  cell_pos;
    logic [CNT_W-1:0]  clamp_pos;

    logic              res_valid_reg, res_valid_next;
    logic [VB-1:0]     entry_reg, entry_next;
    logic [CNT_W-1:0]  count_after_reg, count_after_next;
    logic [pli_pkg::STATUS_BITS-1:0] status_reg, status_next;
    logic              last_reg, last_next;
    logic              res_load;

    logic              out_free;
    logic              req_fire;
    logic              pos_beyond;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;

    logic [WORD_BITS-1:0] val_word;
    logic [WORD_BITS-1:0] cell_data [DEPTH];
    logic [DEPTH:0]       found;

    assign out_free  = !res_valid_reg || !res_stall;
    assign req_stall = !((state_reg == pli_pkg::ST_IDLE) && out_free);
    assign req_fire  = req_valid && !req_stall;

    assign val_word   = WORD_BITS'(value);
    assign pos_ext    = CMP_W'(position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign pos_beyond = (pos_ext >= cnt_ext);
    // position clamped to the count; fits the count width in either branch
    assign clamp_pos  = pos_beyond ? count_reg : CNT_W'(position);

    assign found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = val_word;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign right_w = val_word;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        pli_cell #(
            .WORD_BITS (WORD_BITS),
            .CNT_W     (CNT_W),
            .INDEX     (i)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .pos        (cell_pos),
            .count      (count_reg),
            .value      (val_word),
            .left_data  (left_w),
            .right_data (right_w),
            .head_data  (cell_data[0]),
            .found_in   (found[i]),
            .found_out  (found[i+1]),
            .data       (cell_data[i])
        );
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        dump_left_next   = dump_left_reg;
        cell_op          = pli_pkg::CELL_HOLD;
        cell_pos         = clamp_pos;
        res_load         = 1'b0;
        entry_next       = entry_reg;
        count_after_next = count_after_reg;
        status_next      = status_reg;
        last_next        = last_reg;

        case (state_reg)
            pli_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    entry_next  = '0;
                    status_next = pli_pkg::STATUS_OK;
                    last_next   = 1'b1;
                    res_load    = 1'b1;
                    case (req_type)
                        pli_pkg::REQ_INSERT:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                status_next = pli_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                cell_op    = pli_pkg::CELL_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        pli_pkg::REQ_REMOVE_POS:
                        begin
                            if (pos_beyond)
                            begin
                                status_next = pli_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                cell_op    = pli_pkg::CELL_DELETE;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        pli_pkg::REQ_REMOVE_VAL:
                        begin
                            cell_op = pli_pkg::CELL_DELVAL;
                            if (found[DEPTH])
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                status_next = pli_pkg::STATUS_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            // dump: an empty list answers at once
                            if (count_reg != '0)
                            begin
                                res_load       = 1'b0;
                                dump_left_next = count_reg;
                                state_next     = pli_pkg::ST_DUMP;
                            end
                        end
                    endcase
                    count_after_next = count_next;
                end
            end
            pli_pkg::ST_DUMP:
            begin
                cell_pos = count_reg - 1'b1;
                if (out_free)
                begin
                    cell_op          = pli_pkg::CELL_ROTATE;
                    res_load         = 1'b1;
                    entry_next       = VB'(cell_data[0]);
                    count_after_next = count_reg;
                    status_next      = pli_pkg::STATUS_OK;
                    last_next        = (dump_left_reg == CNT_W'(1));
                    dump_left_next   = dump_left_reg - 1'b1;
                    if (dump_left_reg == CNT_W'(1))
                    begin
                        state_next = pli_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = pli_pkg::ST_IDLE;
            end
        endcase

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pli_pkg::ST_IDLE;
            count_reg     <= '0;
            dump_left_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_left_reg <= dump_left_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg       <= entry_next;
        count_after_reg <= count_after_next;
        status_reg      <= status_next;
        last_reg        <= last_next;
    end

    assign res_valid   = res_valid_reg;
    assign entry       = entry_reg;
    assign count_after = count_after_reg;
    assign status      = status_reg;
    assign last        = last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("list count exceeds depth");

    a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !req_fire |=> count_reg == $past(count_reg))
        else $error("count changed without an accepted request");

    a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pli_pkg::ST_DUMP) |-> req_stall)
        else $error("request accepted during dump");

    a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pli_pkg::ST_DUMP && out_free && dump_left_reg == CNT_W'(1))
        |=> (state_reg == pli_pkg::ST_IDLE && res_valid_reg && last_reg))
        else $error("dump did not end on its final entry");
`endif

endmodule

@@ sim/positional_list_insert_remove_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_insert_remove_tb
// Self-checking bench for the positional word list. A scoreboard keeps its
// own copy of the list and predicts every result of insert, remove by
// position, remove by value and dump requests. Directed cases on the empty,
// partly filled and full list are followed by random traffic, with random gaps
// on the request side and random stalls on the result side, then neither.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_tb;

    localparam int DEPTH        = 16;
    localparam int COUNT_BITS   = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef logic [pli_pkg::POS_BITS-1:0] pos_t;

    typedef struct packed {
        logic [pli_pkg::VALUE_BITS-1:0]  entry;
        logic [COUNT_BITS-1:0]           count_after;
        logic [pli_pkg::STATUS_BITS-1:0] status;
        logic                            last;
    } list_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            req_valid;
    logic                            req_stall;
    logic [pli_pkg::REQ_BITS-1:0]    req_type;
    logic [pli_pkg::POS_BITS-1:0]    position;
    logic [pli_pkg::VALUE_BITS-1:0]  value;
    logic                            res_valid;
    logic                            res_stall;
    logic [pli_pkg::VALUE_BITS-1:0]  entry;
    logic [COUNT_BITS-1:0]           count_after;
    logic [pli_pkg::STATUS_BITS-1:0] status;
    logic                            last;

    // scoreboard copy of the list
    logic [pli_pkg::VALUE_BITS-1:0]  list_words [DEPTH];
    int                              list_count;
    list_result_t                    pending_results [$];
    list_result_t                    oldest_result;

    int                              error_count;
    int                              cycle_count;
    int                              res_hold_left;
    bit                              quiet;

    positional_list_insert_remove #(
        .DEPTH     (DEPTH),
        .WORD_BITS (pli_pkg::VALUE_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .position    (position),
        .value       (value),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .entry       (entry),
        .count_after (count_after),
        .status      (status),
        .last        (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int draw_gap();
        if (quiet || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [pli_pkg::VALUE_BITS-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            // small pool so duplicates show up
            2: return $urandom_range(1, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic pos_t pick_pos();
        if ($urandom_range(0, 3) == 0)
            return pos_t'($urandom_range(0, 255));
        return pos_t'($urandom_range(0, list_count));
    endfunction

    task automatic push_result(input logic [pli_pkg::VALUE_BITS-1:0] word,
                               input logic [pli_pkg::STATUS_BITS-1:0] code,
                               input logic fin);
        list_result_t r;
        r.entry       = word;
        r.count_after = COUNT_BITS'(list_count);
        r.status      = code;
        r.last        = fin;
        pending_results.push_back(r);
    endtask

    task automatic drop_slot(input int slot);
        int i;
        for (i = slot; i + 1 < list_count; i++)
            list_words[i] = list_words[i + 1];
        list_count--;
    endtask

    task automatic apply_list_request(input logic [pli_pkg::REQ_BITS-1:0] kind,
                                      input logic [pli_pkg::POS_BITS-1:0] pos,
                                      input logic [pli_pkg::VALUE_BITS-1:0] word);
        int i;
        int slot;
        int hit;
        case (kind)
            pli_pkg::REQ_INSERT:
            begin
                if (list_count >= DEPTH)
                    push_result('0, pli_pkg::STATUS_FULL, 1'b1);
                else
                begin
                    slot = (pos > list_count) ? list_count : int'(pos);
                    for (i = list_count; i > slot; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[slot] = word;
                    list_count++;
                    push_result('0, pli_pkg::STATUS_OK, 1'b1);
                end
            end
            pli_pkg::REQ_REMOVE_POS:
            begin
                if (pos >= list_count)
                    push_result('0, pli_pkg::STATUS_RANGE, 1'b1);
                else
                begin
                    drop_slot(int'(pos));
                    push_result('0, pli_pkg::STATUS_OK, 1'b1);
                end
            end
            pli_pkg::REQ_REMOVE_VAL:
            begin
                hit = -1;
                for (i = 0; i < list_count; i++)
                    if (hit < 0 && list_words[i] == word)
                        hit = i;
                if (hit < 0)
                    push_result('0, pli_pkg::STATUS_NOT_FOUND, 1'b1);
                else
                begin
                    drop_slot(hit);
                    push_result('0, pli_pkg::STATUS_OK, 1'b1);
                end
            end
            default:
            begin
                if (list_count == 0)
                    push_result('0, pli_pkg::STATUS_OK, 1'b1);
                else
                    for (i = 0; i < list_count; i++)
                        push_result(list_words[i], pli_pkg::STATUS_OK,
                                    i == list_count - 1);
            end
        endcase
    endtask

    // keep valid high across back-to-back requests; lower it only for a gap
    task automatic send_req(input logic [pli_pkg::REQ_BITS-1:0] kind,
                            input logic [pli_pkg::POS_BITS-1:0] pos,
                            input logic [pli_pkg::VALUE_BITS-1:0] word);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        position  <= pos;
        value     <= word;
        do
            @(posedge clk);
        while (req_stall);
        apply_list_request(kind, pos, word);
    endtask

    task automatic test_empty_list();
        send_req(pli_pkg::REQ_DUMP, 8'd0, '0);
        send_req(pli_pkg::REQ_REMOVE_POS, 8'd0, '0);
        send_req(pli_pkg::REQ_REMOVE_POS, 8'd255, '1);
        send_req(pli_pkg::REQ_REMOVE_VAL, 8'd0, '0);
    endtask

    task automatic test_insert_remove_basics();
        send_req(pli_pkg::REQ_INSERT, 8'd0, '0);
        send_req(pli_pkg::REQ_INSERT, 8'd255, '1);
        send_req(pli_pkg::REQ_INSERT, 8'd1, 32'h5a5a_a5a5);
        send_req(pli_pkg::REQ_INSERT, 8'd0, 32'h0000_0001);
        send_req(pli_pkg::REQ_INSERT, 8'd3, 32'h8000_0000);
        send_req(pli_pkg::REQ_INSERT, 8'd5, 32'h1234_5678);
        send_req(pli_pkg::REQ_DUMP, 8'd0, '0);
        send_req(pli_pkg::REQ_REMOVE_VAL, 8'd0, '1);
        send_req(pli_pkg::REQ_REMOVE_VAL, 8'd0, 32'hdead_beef);
        send_req(pli_pkg::REQ_REMOVE_POS, pos_t'(list_count), '0);
        send_req(pli_pkg::REQ_REMOVE_POS, 8'd0, '0);
        // a duplicate at the tail: remove by value must take the first one
        send_req(pli_pkg::REQ_INSERT, 8'd200, '0);
        send_req(pli_pkg::REQ_REMOVE_VAL, 8'd7, '0);
        send_req(pli_pkg::REQ_DUMP, 8'd0, '0);
    endtask

    task automatic test_full_list();
        while (list_count < DEPTH)
            send_req(pli_pkg::REQ_INSERT, pick_pos(), pick_word());
        send_req(pli_pkg::REQ_INSERT, 8'd0, 32'hcafe_f00d);
        send_req(pli_pkg::REQ_DUMP, 8'd0, '0);
        send_req(pli_pkg::REQ_REMOVE_POS, pos_t'(DEPTH - 1), '0);
        send_req(pli_pkg::REQ_INSERT, 8'd255, 32'hffff_0000);
        send_req(pli_pkg::REQ_REMOVE_VAL, 8'd0, list_words[DEPTH - 1]);
        send_req(pli_pkg::REQ_INSERT, pos_t'(DEPTH - 1), 32'h0000_ffff);
        send_req(pli_pkg::REQ_DUMP, 8'd0, '0);
        while (list_count > 0)
            send_req(pli_pkg::REQ_REMOVE_POS, 8'd0, $urandom);
        send_req(pli_pkg::REQ_DUMP, 8'd0, '0);
    endtask

    task automatic test_random_mix(input int num_reqs);
        int n;
        logic [pli_pkg::VALUE_BITS-1:0] word;
        for (n = 0; n < num_reqs; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    send_req(pli_pkg::REQ_INSERT, pick_pos(), pick_word());
                4, 5:
                    send_req(pli_pkg::REQ_REMOVE_POS, pick_pos(), $urandom);
                6, 7:
                begin
                    if (list_count > 0 && $urandom_range(0, 2) != 0)
                        word = list_words[$urandom_range(0, list_count - 1)];
                    else
                        word = pick_word();
                    send_req(pli_pkg::REQ_REMOVE_VAL, pos_t'($urandom_range(0, 255)), word);
                end
                default:
                    send_req(pli_pkg::REQ_DUMP, pos_t'($urandom_range(0, 255)), $urandom);
            endcase
        end
    endtask

    task automatic test_back_to_back(input int num_reqs);
        quiet = 1'b1;
        test_random_mix(num_reqs);
        quiet = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: entry %h count_after %0d status %0d last %0b",
                       entry, count_after, status, last);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (entry !== oldest_result.entry)
                begin
                    $error("entry: expected %h, got %h", oldest_result.entry, entry);
                    error_count++;
                end
                if (count_after !== oldest_result.count_after)
                begin
                    $error("count_after: expected %0d, got %0d",
                           oldest_result.count_after, count_after);
                    error_count++;
                end
                if (status !== oldest_result.status)
                begin
                    $error("status: expected %0d, got %0d", oldest_result.status, status);
                    error_count++;
                end
                if (last !== oldest_result.last)
                begin
                    $error("last: expected %0b, got %0b", oldest_result.last, last);
                    error_count++;
                end
            end
            res_hold_left = draw_gap();
        end
    end

    always @(negedge clk)
    begin
        if (res_hold_left > 0)
        begin
            res_stall <= 1'b1;
            res_hold_left--;
        end
        else
            res_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("positional_list_insert_remove test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_type      = pli_pkg::REQ_INSERT;
        position      = '0;
        value         = '0;
        res_stall     = 1'b0;
        res_hold_left = 0;
        list_count    = 0;
        error_count   = 0;
        cycle_count   = 0;
        quiet         = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_insert_remove_basics();
        test_full_list();
        test_random_mix(260);
        test_back_to_back(40);

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("positional_list_insert_remove test passed");
        else
            $display("positional_list_insert_remove test failed");
        $finish;
    end

endmodule
